>>> src/m4t_pkg.sv
package m4t_pkg;

   localparam int COEF_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int OUT_W = 32;

   localparam logic [2:0] REQ_WRITE_CUR = 3'd0;
   localparam logic [2:0] REQ_IDENTITY = 3'd1;
   localparam logic [2:0] REQ_WRITE_OPND = 3'd2;
   localparam logic [2:0] REQ_MULTIPLY = 3'd3;
   localparam logic [2:0] REQ_TRANSFORM = 3'd4;

   // Bit r*4+c is set where the identity matrix holds one.
   localparam logic [15:0] IDENT_PATTERN = 16'b1000_0100_0010_0001;

   typedef struct packed {
      logic issue;
      logic hi;
      logic first;
   } m4t_lane_ctrl_type;

endpackage

>>> src/m4t_lane.sv
module m4t_lane #(
   parameter int COEF_WIDTH = m4t_pkg::COEF_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  m4t_pkg::m4t_lane_ctrl_type      ctrl,
   input  logic signed [COEF_WIDTH-1:0]    coef_a,
   input  logic signed [COEF_WIDTH-1:0]    coef_b,
   output logic signed [2*COEF_WIDTH+1:0]  acc
);
   import m4t_pkg::*;

   localparam int LO_W = COEF_WIDTH / 2;
   localparam int ACC_W = 2 * COEF_WIDTH + 2;

   logic signed [LO_W:0]            b_part;
   logic signed [COEF_WIDTH+LO_W:0] prod_in;
   logic signed [COEF_WIDTH+LO_W:0] prod_ff;
   logic                            pend_ff;
   logic                            pend_in;
   logic                            pend_hi_ff;
   logic                            pend_first_ff;
   logic signed [ACC_W-1:0]         term;
   logic signed [ACC_W-1:0]         acc_ff;
   logic signed [ACC_W-1:0]         acc_in;

   // The second operand is taken in two slices: an unsigned low half and a
   // signed high half, so the multiplier is only about half as wide.
   always_comb begin
      if (ctrl.hi) begin
         b_part = (LO_W+1)'($signed(coef_b[COEF_WIDTH-1:LO_W]));
      end else begin
         b_part = $signed({1'b0, coef_b[LO_W-1:0]});
      end
      prod_in = coef_a * b_part;
   end

   always_comb begin
      if (pend_hi_ff) begin
         term = ACC_W'(prod_ff) <<< LO_W;
      end else begin
         term = ACC_W'(prod_ff);
      end
      pend_in = ctrl.issue;
      acc_in = acc_ff;
      if (pend_ff) begin
         acc_in = pend_first_ff ? term : acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pend_hi_ff <= ctrl.hi;
      pend_first_ff <= ctrl.first;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> src/m4t_merge.sv
module m4t_merge #(
   parameter int COEF_WIDTH = m4t_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS = m4t_pkg::FRAC_BITS_DEF
) (
   input  logic signed [2*COEF_WIDTH+1:0]  acc [4],
   output logic signed [COEF_WIDTH-1:0]    sat_coef [4],
   output logic signed [m4t_pkg::OUT_W-1:0] sat_out [4]
);
   import m4t_pkg::*;

   localparam int ACC_W = 2 * COEF_WIDTH + 2;

   logic signed [ACC_W-1:0] shifted [4];

   // Each lane's sum is scaled back by the fraction bits, rounding towards
   // minus infinity, and clamped to the coefficient and output ranges.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         shifted[i] = acc[i] >>> FRAC_BITS;
         if ((&shifted[i][ACC_W-1:COEF_WIDTH-1]) || !(|shifted[i][ACC_W-1:COEF_WIDTH-1])) begin
            sat_coef[i] = shifted[i][COEF_WIDTH-1:0];
         end else if (shifted[i][ACC_W-1]) begin
            sat_coef[i] = {1'b1, {(COEF_WIDTH-1){1'b0}}};
         end else begin
            sat_coef[i] = {1'b0, {(COEF_WIDTH-1){1'b1}}};
         end
         if ((&shifted[i][ACC_W-1:OUT_W-1]) || !(|shifted[i][ACC_W-1:OUT_W-1])) begin
            sat_out[i] = shifted[i][OUT_W-1:0];
         end else if (shifted[i][ACC_W-1]) begin
            sat_out[i] = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            sat_out[i] = {1'b0, {(OUT_W-1){1'b1}}};
         end
      end
   end

endmodule

>>> src/matrix4_transform_unit.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_type, req_elem_index, req_elem_value, req_vec_*
// rsp_      out        rsp_valid/rsp_stall   rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w
//
// Writes and identity complete on acceptance; a transform runs through RUN, ACC and FINISH to a
// registered result, and a matrix multiply repeats that pass once for each of the four columns.
// Each of the four row lanes has one multiplier that takes half of the second operand per
// cycle, low half then high half, and sums four terms per dot product.
// Reset loads the identity into the current matrix; the operand matrix is not cleared.
// A finished transform waits only while the previous result is still stalled.
module matrix4_transform_unit #(
   parameter int COEF_WIDTH = m4t_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS = m4t_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_type,
   input  logic [3:0]           req_elem_index,
   input  logic signed [31:0]   req_elem_value,
   input  logic signed [31:0]   req_vec_x,
   input  logic signed [31:0]   req_vec_y,
   input  logic signed [31:0]   req_vec_z,
   input  logic signed [31:0]   req_vec_w,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic signed [31:0]   rsp_out_w
);
   import m4t_pkg::*;

   localparam int ACC_W = 2 * COEF_WIDTH + 2;
   localparam logic [COEF_WIDTH-1:0] ONE_VAL = COEF_WIDTH'(64'd1 << FRAC_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN = 2'd1;
   localparam logic [1:0] ST_ACC = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;
   logic [1:0] col_ff;
   logic [1:0] col_in;
   logic       xform_ff;
   logic       xform_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Current matrix is held column by column, each word carrying all four rows.
   logic signed [COEF_WIDTH-1:0] cur_ff [4][4];
   logic signed [COEF_WIDTH-1:0] prod_ff [3][4];
   logic signed [COEF_WIDTH-1:0] opnd_ff [16];
   logic signed [COEF_WIDTH-1:0] vec_ff [4];
   logic signed [31:0]           rsp_out_ff [4];

   logic                         accept;
   logic [1:0]                   k_sel;
   logic signed [COEF_WIDTH-1:0] cur_col [4];
   logic signed [COEF_WIDTH-1:0] b_sel;
   m4t_lane_ctrl_type            lane_ctrl;
   logic signed [ACC_W-1:0]      lane_acc [4];
   logic signed [COEF_WIDTH-1:0] sat_coef [4];
   logic signed [OUT_W-1:0]      sat_out [4];
   logic                         rsp_free;
   logic                         finish_xform;
   logic                         finish_mul;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_free = !(rsp_valid_ff && rsp_stall);
   assign finish_xform = (state_ff == ST_FINISH) && xform_ff && rsp_free;
   assign finish_mul = (state_ff == ST_FINISH) && !xform_ff;

   always_comb begin
      k_sel = cnt_ff[2:1];
      cur_col = cur_ff[k_sel];
      b_sel = xform_ff ? vec_ff[k_sel] : opnd_ff[{k_sel, col_ff}];
      lane_ctrl.issue = (state_ff == ST_RUN);
      lane_ctrl.hi = cnt_ff[0];
      lane_ctrl.first = (cnt_ff == 3'd0);
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      m4t_lane #(
         .COEF_WIDTH(COEF_WIDTH)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .coef_a(cur_col[i]),
         .coef_b(b_sel),
         .acc   (lane_acc[i])
      );
   end

   m4t_merge #(
      .COEF_WIDTH(COEF_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .acc     (lane_acc),
      .sat_coef(sat_coef),
      .sat_out (sat_out)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      col_in = col_ff;
      xform_in = xform_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_MULTIPLY || req_type == REQ_TRANSFORM)) begin
               state_in = ST_RUN;
               cnt_in = 3'd0;
               col_in = 2'd0;
               xform_in = (req_type == REQ_TRANSFORM);
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_xform) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else if (finish_mul) begin
               if (col_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  col_in = col_ff + 2'd1;
                  cnt_in = 3'd0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 3'd0;
         col_ff <= 2'd0;
         xform_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         col_ff <= col_in;
         xform_ff <= xform_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_type == REQ_IDENTITY)) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               cur_ff[c][r] <= IDENT_PATTERN[4'(r * 4 + c)] ? ONE_VAL : '0;
            end
         end
      end else if (accept && req_type == REQ_WRITE_CUR) begin
         cur_ff[req_elem_index[1:0]][req_elem_index[3:2]] <= COEF_WIDTH'(req_elem_value);
      end else if (finish_mul && col_ff == 2'd3) begin
         for (int c = 0; c < 3; c++) begin
            cur_ff[c] <= prod_ff[c];
         end
         cur_ff[3] <= sat_coef;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_mul && col_ff != 2'd3) begin
         prod_ff[col_ff] <= sat_coef;
      end
      if (accept && req_type == REQ_WRITE_OPND) begin
         opnd_ff[req_elem_index] <= COEF_WIDTH'(req_elem_value);
      end
      if (accept && req_type == REQ_TRANSFORM) begin
         vec_ff[0] <= COEF_WIDTH'(req_vec_x);
         vec_ff[1] <= COEF_WIDTH'(req_vec_y);
         vec_ff[2] <= COEF_WIDTH'(req_vec_z);
         vec_ff[3] <= COEF_WIDTH'(req_vec_w);
      end
      if (finish_xform) begin
         rsp_out_ff <= sat_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_out_ff[0];
   assign rsp_out_y = rsp_out_ff[1];
   assign rsp_out_z = rsp_out_ff[2];
   assign rsp_out_w = rsp_out_ff[3];

   a_start_run: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == REQ_MULTIPLY || req_type == REQ_TRANSFORM)
      |=> state_ff == ST_RUN && cnt_ff == 3'd0)
      else $error("multiply or transform did not start its first pass");

   a_acc_after_last_term: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> $past(state_ff == ST_RUN && cnt_ff == 3'd7))
      else $error("final accumulate not preceded by the last term");

   a_rsp_from_xform: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH && xform_ff))
      else $error("result raised outside a finished transform");

   a_mul_ends: assert property (@(posedge clock) disable iff (reset)
      finish_mul && col_ff == 2'd3 |=> state_ff == ST_IDLE)
      else $error("multiply did not end after the last column");

endmodule
